@@ rtl/zsse_pkg.sv @@
// ----------------------------------------------------------------------------
// zsse_pkg
// Types and constants shared by the stored-block zlib stream encoder.
// ----------------------------------------------------------------------------
package zsse_pkg;

   localparam int BLOCK_MAX_DEF = 65535;
   localparam int MAX_WORDS     = 12;
   localparam int CNT_W         = $clog2(MAX_WORDS + 1);
   localparam int ADDR_W        = 3;

   localparam logic [15:0] ADLER_MOD = 16'd65521;
   localparam logic [7:0]  ZLIB_CMF  = 8'h78;
   localparam logic [7:0]  ZLIB_FLG  = 8'h01;

   // register index, taken from paddr[2]
   localparam logic REG_STREAM_LENGTH = 1'b0;

   localparam logic KIND_BYTE   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   typedef struct packed {
      logic       kind;
      logic [7:0] data_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       stream_end;
   } rsp_word_type;

endpackage

@@ rtl/zsse_adler.sv @@
// ----------------------------------------------------------------------------
// zsse_adler
// One Adler-32 step: folds a byte into both running sums modulo 65521.
// ----------------------------------------------------------------------------
module zsse_adler (
   input  logic [15:0] sum_a,
   input  logic [15:0] sum_b,
   input  logic [7:0]  data_byte,
   output logic [15:0] sum_a_next,
   output logic [15:0] sum_b_next
);
   import zsse_pkg::*;

   logic [16:0] a_raw;
   logic [16:0] b_raw;

   // both sums stay below the modulus, so one conditional subtract suffices
   always_comb begin
      a_raw = {1'b0, sum_a} + {9'd0, data_byte};
      if (a_raw >= {1'b0, ADLER_MOD}) begin
         a_raw = a_raw - {1'b0, ADLER_MOD};
      end
      sum_a_next = a_raw[15:0];
      b_raw = {1'b0, sum_b} + {1'b0, sum_a_next};
      if (b_raw >= {1'b0, ADLER_MOD}) begin
         b_raw = b_raw - {1'b0, ADLER_MOD};
      end
      sum_b_next = b_raw[15:0];
   end

endmodule

@@ rtl/zlib_stored_stream_encoder_core.sv @@
// ----------------------------------------------------------------------------
// zlib_stored_stream_encoder_core
// Wraps a byte stream in a zlib stream of stored deflate blocks with an
// Adler-32 trailer.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            word
//  req       in    req_valid/req_stall  kind, data_byte
//  rsp       out   rsp_valid/rsp_stall  out_byte, run_last, stream_end
//  csr       in    APB write/read       stream_length at address 0
//
// Each accepted word is turned into 0 to 12 output words (a finish inside a
// stream gives none): a payload byte inside a block yields a single word,
// and one that opens a block or ends the stream also yields header or trailer
// words. They are loaded into a 12-entry output shift buffer, which drains
// one word per cycle while rsp_stall is low.
// A new word is taken when the buffer is empty or its last word leaves.
// Reset is synchronous; it clears the stream state and empties the buffer.
module zlib_stored_stream_encoder_core #(
   parameter int BLOCK_MAX = zsse_pkg::BLOCK_MAX_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  zsse_pkg::req_word_type        req_word,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output zsse_pkg::rsp_word_type        rsp_word,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [zsse_pkg::ADDR_W-1:0]   paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import zsse_pkg::*;

   logic [31:0]  stream_length_ff;
   logic [31:0]  bytes_rem_ff, bytes_rem_in;
   logic [15:0]  block_rem_ff, block_rem_in;
   logic [15:0]  sum_a_ff, sum_a_in;
   logic [15:0]  sum_b_ff, sum_b_in;
   logic         started_ff, started_in;

   rsp_word_type             buf_ff [MAX_WORDS];
   rsp_word_type             buf_in [MAX_WORDS];
   logic [CNT_W-1:0]         cnt_ff, cnt_in;

   rsp_word_type             list_w [MAX_WORDS];
   logic [CNT_W-1:0]         n_words;

   logic         req_fire;
   logic         pop;
   logic         csr_write;
   logic [15:0]  sum_a_step, sum_b_step;
   logic [31:0]  br_eff;
   logic [15:0]  blk_eff;
   logic [31:0]  take32;
   logic [15:0]  take;
   logic         final_blk;
   logic [31:0]  br_next;

   // ---------------- configuration port ----------------
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == REG_STREAM_LENGTH) ? stream_length_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stream_length_ff <= 32'd0;
      end else if (csr_write && paddr[2] == REG_STREAM_LENGTH) begin
         stream_length_ff <= pwdata;
      end
   end

   // ---------------- handshake ----------------
   assign rsp_valid = (cnt_ff != '0);
   assign rsp_word  = buf_ff[0];
   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = !((cnt_ff == '0) || (cnt_ff == CNT_W'(1) && !rsp_stall));
   assign req_fire  = req_valid && !req_stall;

   zsse_adler u_adler (
      .sum_a      (sum_a_ff),
      .sum_b      (sum_b_ff),
      .data_byte  (req_word.data_byte),
      .sum_a_next (sum_a_step),
      .sum_b_next (sum_b_step)
   );

   // ---------------- word expansion ----------------
   assign br_eff    = started_ff ? bytes_rem_ff : stream_length_ff;
   assign blk_eff   = started_ff ? block_rem_ff : 16'd0;
   assign take32    = (br_eff > 32'(BLOCK_MAX)) ? 32'(BLOCK_MAX) : br_eff;
   assign take      = take32[15:0];
   assign final_blk = (br_eff <= 32'(BLOCK_MAX));
   assign br_next   = br_eff - 32'd1;

   always_comb begin
      logic [CNT_W-1:0] pos;
      pos          = '0;
      started_in   = started_ff;
      bytes_rem_in = bytes_rem_ff;
      block_rem_in = block_rem_ff;
      sum_a_in     = sum_a_ff;
      sum_b_in     = sum_b_ff;
      for (int i = 0; i < MAX_WORDS; i++) begin
         list_w[i] = '0;
      end

      if (!started_ff && (req_word.kind == KIND_FINISH || stream_length_ff == 32'd0)) begin
         // complete empty stream, sums at their initial values
         list_w[0]  = '{ZLIB_CMF, 1'b0, 1'b0};
         list_w[1]  = '{ZLIB_FLG, 1'b0, 1'b0};
         list_w[2]  = '{8'h01,    1'b0, 1'b0};
         list_w[3]  = '{8'h00,    1'b0, 1'b0};
         list_w[4]  = '{8'h00,    1'b0, 1'b0};
         list_w[5]  = '{8'hFF,    1'b0, 1'b0};
         list_w[6]  = '{8'hFF,    1'b0, 1'b0};
         list_w[7]  = '{8'h00,    1'b0, 1'b0};
         list_w[8]  = '{8'h00,    1'b0, 1'b0};
         list_w[9]  = '{8'h00,    1'b0, 1'b0};
         list_w[10] = '{8'h01,    1'b0, 1'b1};
         pos = CNT_W'(11);
      end else if (started_ff && req_word.kind == KIND_FINISH) begin
         pos = '0;
      end else begin
         if (!started_ff) begin
            list_w[pos] = '{ZLIB_CMF, 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{ZLIB_FLG, 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
         end
         if (blk_eff == 16'd0) begin
            list_w[pos] = '{{7'd0, final_blk}, 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{take[7:0], 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{take[15:8], 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{~take[7:0], 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{~take[15:8], 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
         end
         list_w[pos] = '{req_word.data_byte, 1'b0, 1'b0};
         pos = pos + CNT_W'(1);

         if (br_next == 32'd0) begin
            list_w[pos] = '{sum_b_step[15:8], 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{sum_b_step[7:0], 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{sum_a_step[15:8], 1'b0, 1'b0};
            pos = pos + CNT_W'(1);
            list_w[pos] = '{sum_a_step[7:0], 1'b0, 1'b1};
            pos = pos + CNT_W'(1);
            started_in   = 1'b0;
            bytes_rem_in = 32'd0;
            block_rem_in = 16'd0;
            sum_a_in     = 16'd1;
            sum_b_in     = 16'd0;
         end else begin
            started_in   = 1'b1;
            bytes_rem_in = br_next;
            block_rem_in = ((blk_eff == 16'd0) ? take : blk_eff) - 16'd1;
            sum_a_in     = sum_a_step;
            sum_b_in     = sum_b_step;
         end
      end

      if (pos != '0) begin
         list_w[pos - CNT_W'(1)].run_last = 1'b1;
      end
      n_words = pos;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         bytes_rem_ff <= 32'd0;
         block_rem_ff <= 16'd0;
         sum_a_ff     <= 16'd1;
         sum_b_ff     <= 16'd0;
      end else if (req_fire) begin
         started_ff   <= started_in;
         bytes_rem_ff <= bytes_rem_in;
         block_rem_ff <= block_rem_in;
         sum_a_ff     <= sum_a_in;
         sum_b_ff     <= sum_b_in;
      end
   end

   // ---------------- output shift buffer ----------------
   always_comb begin
      cnt_in = cnt_ff;
      for (int i = 0; i < MAX_WORDS; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (req_fire) begin
         cnt_in = n_words;
         for (int i = 0; i < MAX_WORDS; i++) begin
            buf_in[i] = list_w[i];
         end
      end else if (pop) begin
         cnt_in = cnt_ff - CNT_W'(1);
         for (int i = 0; i < MAX_WORDS - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_WORDS; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

   // ---------------- assertions ----------------
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.stream_end |-> rsp_word.run_last)
      else $error("stream_end word not marked run_last");

   a_last_only_at_tail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && cnt_ff > CNT_W'(1) |-> !rsp_word.run_last)
      else $error("run_last shown before the final buffered word");

   a_end_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.stream_end |-> !started_ff)
      else $error("trailer shown while a stream is still open");

   a_idle_sums: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> sum_a_ff == 16'd1 && sum_b_ff == 16'd0 && block_rem_ff == 16'd0)
      else $error("idle state not at its initial values");

   a_sums_reduced: assert property (@(posedge clock) disable iff (reset)
      sum_a_ff < ADLER_MOD && sum_b_ff < ADLER_MOD)
      else $error("Adler sum not reduced");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the stored-block zlib stream encoder: payload and
// finish words are pushed in with random gaps, every output byte is checked
// against an in-bench encoder model (headers, block lengths, Adler-32 trailer),
// and the stream_length register is exercised over the APB port.
// ----------------------------------------------------------------------------
module testbench;
   import zsse_pkg::*;

   localparam int TB_BLOCK_MAX = BLOCK_MAX_DEF;
   localparam logic [ADDR_W-1:0] ADDR_STREAM_LENGTH = {REG_STREAM_LENGTH, 2'b00};
   localparam logic [ADDR_W-1:0] ADDR_NO_REG        = {~REG_STREAM_LENGTH, 2'b00};
   localparam int SETTLE_CYCLES = 20;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   req_word_type      req_word;
   logic              rsp_valid;
   logic              rsp_stall;
   rsp_word_type      rsp_word;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [31:0]       pwdata;
   logic [31:0]       prdata;
   logic              pready;

   zlib_stored_stream_encoder_core #(
      .BLOCK_MAX(TB_BLOCK_MAX)
   ) u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #5_000_000;
      $display("status: fail");
      $finish;
   end

   // encoder model state
   logic [31:0]  cfg_stream_len;
   logic [31:0]  left_total;
   logic [15:0]  left_in_block;
   logic [15:0]  adler_a;
   logic [15:0]  adler_b;
   logic         in_stream;
   rsp_word_type expected_bytes[$];

   int unsigned errors;
   int unsigned words_sent;
   int unsigned bytes_checked;
   int unsigned streams_done;
   int unsigned req_max_gap;
   int unsigned rsp_max_gap;
   int unsigned hold_left;

   function automatic void push_byte(logic [7:0] b, logic last_of_stream);
      rsp_word_type r;
      r.out_byte   = b;
      r.run_last   = 1'b0;
      r.stream_end = last_of_stream;
      expected_bytes.push_back(r);
   endfunction

   function automatic void push_block_header(logic [15:0] len, logic bfinal);
      logic [15:0] nlen;
      nlen = ~len;
      push_byte({7'd0, bfinal}, 1'b0);
      push_byte(len[7:0], 1'b0);
      push_byte(len[15:8], 1'b0);
      push_byte(nlen[7:0], 1'b0);
      push_byte(nlen[15:8], 1'b0);
   endfunction

   function automatic void push_adler(logic [15:0] a, logic [15:0] b);
      push_byte(b[15:8], 1'b0);
      push_byte(b[7:0], 1'b0);
      push_byte(a[15:8], 1'b0);
      push_byte(a[7:0], 1'b1);
   endfunction

   function automatic void reset_stream();
      in_stream     = 1'b0;
      left_total    = '0;
      left_in_block = '0;
      adler_a       = 16'd1;
      adler_b       = 16'd0;
   endfunction

   // expected output bytes for one accepted input word
   function automatic void encode_word(req_word_type w);
      int unsigned before_n;
      logic [31:0] take;
      logic [16:0] acc;
      before_n = expected_bytes.size();
      if (!in_stream) begin
         push_byte(ZLIB_CMF, 1'b0);
         push_byte(ZLIB_FLG, 1'b0);
         if (w.kind == KIND_FINISH || cfg_stream_len == 0) begin
            push_block_header(16'd0, 1'b1);
            reset_stream();
            push_adler(adler_a, adler_b);
            expected_bytes[expected_bytes.size()-1].run_last = 1'b1;
            streams_done++;
            return;
         end
         in_stream     = 1'b1;
         left_total    = cfg_stream_len;
         left_in_block = '0;
         adler_a       = 16'd1;
         adler_b       = 16'd0;
      end else if (w.kind == KIND_FINISH) begin
         return;   // ignored mid-stream
      end
      if (left_in_block == 0) begin
         take = (left_total > 32'(TB_BLOCK_MAX)) ? 32'(TB_BLOCK_MAX) : left_total;
         push_block_header(take[15:0], take == left_total);
         left_in_block = take[15:0];
      end
      push_byte(w.data_byte, 1'b0);
      acc = {1'b0, adler_a} + {9'd0, w.data_byte};
      if (acc >= {1'b0, ADLER_MOD}) acc = acc - {1'b0, ADLER_MOD};
      adler_a = acc[15:0];
      acc = {1'b0, adler_b} + {1'b0, adler_a};
      if (acc >= {1'b0, ADLER_MOD}) acc = acc - {1'b0, ADLER_MOD};
      adler_b = acc[15:0];
      left_in_block = left_in_block - 16'd1;
      left_total    = left_total - 32'd1;
      if (left_total == 0) begin
         push_adler(adler_a, adler_b);
         reset_stream();
         streams_done++;
      end
      if (expected_bytes.size() > before_n)
         expected_bytes[expected_bytes.size()-1].run_last = 1'b1;
   endfunction

   // output checker, samples values from before the edge
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_bytes.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected output word %h/%b/%b", $time,
                        rsp_word.out_byte, rsp_word.run_last, rsp_word.stream_end);
         end else begin
            rsp_word_type exp_w;
            exp_w = expected_bytes.pop_front();
            bytes_checked++;
            if (rsp_word !== exp_w) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: byte %0d mismatch exp %h/%b/%b got %h/%b/%b", $time,
                           bytes_checked, exp_w.out_byte, exp_w.run_last,
                           exp_w.stream_end, rsp_word.out_byte, rsp_word.run_last,
                           rsp_word.stream_end);
            end
         end
      end
   end

   // output sink: random stall per word plus an optional long hold-off
   initial begin : rsp_sink
      int unsigned stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall && stall_left == 0)
            stall_left = $urandom_range(0, rsp_max_gap);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // leaves req_valid high after acceptance so back-to-back words stay valid
   task automatic send_word(input logic kind, input logic [7:0] b);
      int unsigned gap;
      req_word_type w;
      w.kind      = kind;
      w.data_byte = b;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      encode_word(w);
      words_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr[2] == REG_STREAM_LENGTH)
         cfg_stream_len = data;
   endtask

   task automatic csr_check_length();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= ADDR_STREAM_LENGTH;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== cfg_stream_len) begin
         errors++;
         if (errors <= 10)
            $display("%0t: stream_length readback exp %h got %h", $time,
                     cfg_stream_len, prdata);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_length(input logic [31:0] len);
      csr_write(ADDR_STREAM_LENGTH, len);
      csr_check_length();
   endtask

   // full stream of len bytes; noisy mixes ignored finish words in
   task automatic send_stream(input int unsigned len, input bit noisy,
                              input int unsigned lo, input int unsigned hi);
      for (int unsigned i = 0; i < len; i++) begin
         if (noisy && i > 0 && $urandom_range(0, 7) == 0)
            send_word(KIND_FINISH, 8'($urandom));
         send_word(KIND_BYTE, 8'($urandom_range(lo, hi)));
      end
   endtask

   task automatic test_empty_streams();
      set_length(32'd0);
      send_word(KIND_FINISH, 8'h00);
      send_word(KIND_BYTE, 8'hFF);    // zero length turns a byte into a finish
      wait_idle();
      set_length(32'hFFFF_FFFF);
      send_word(KIND_FINISH, 8'hA5);  // finish while idle ignores the length
      wait_idle();
      csr_write(ADDR_NO_REG, 32'd3);  // unmapped, must not land
      csr_check_length();
   endtask

   task automatic test_short_streams();
      set_length(32'd1);
      send_word(KIND_BYTE, 8'h00);
      wait_idle();
      set_length(32'd3);
      send_word(KIND_BYTE, 8'hFF);
      send_word(KIND_FINISH, 8'hFF);  // mid-stream finish is dropped
      send_word(KIND_BYTE, 8'h80);
      send_word(KIND_BYTE, 8'h01);
      wait_idle();
   endtask

   // longer than one block: first block is capped with BFINAL clear; the
   // stream is left open at the end of the run
   task automatic test_block_cap();
      req_max_gap = 3;
      rsp_max_gap = 3;
      set_length(32'(TB_BLOCK_MAX) + 32'd2);
      send_stream(6, 1'b1, 0, 255);
      wait_idle();
   endtask

   task automatic test_adler_wrap();
      req_max_gap = 2;
      rsp_max_gap = 2;
      set_length(32'd264);            // enough high bytes to wrap sum_a
      send_stream(264, 1'b0, 250, 255);
      wait_idle();
   endtask

   task automatic test_backpressure();
      req_max_gap = 0;
      rsp_max_gap = 0;
      set_length(32'd20);
      hold_left = 300;
      send_stream(20, 1'b0, 0, 255);
      wait_idle();
   endtask

   task automatic test_random_streams();
      int unsigned start_n;
      int unsigned len;
      int unsigned pick;
      start_n = words_sent;
      while (words_sent - start_n < 16) begin
         req_max_gap = $urandom_range(0, 1) ? 9 : 0;
         rsp_max_gap = $urandom_range(0, 1) ? 9 : 0;
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            set_length($urandom);
            send_word(KIND_FINISH, 8'($urandom));
         end else if (pick == 1) begin
            set_length(32'd0);
            send_word(KIND_BYTE, 8'($urandom));
         end else begin
            len = (pick == 2) ? $urandom_range(8, 16) : $urandom_range(1, 6);
            set_length(len);
            send_stream(len, $urandom_range(0, 2) == 0, 0, 255);
         end
         wait_idle();
      end
   endtask

   initial begin
      errors        = 0;
      words_sent    = 0;
      bytes_checked = 0;
      streams_done  = 0;
      hold_left     = 0;
      req_max_gap   = 3;
      rsp_max_gap   = 3;
      cfg_stream_len = '0;
      reset_stream();
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_streams();
      test_short_streams();
      test_adler_wrap();
      test_backpressure();
      test_random_streams();
      test_block_cap();
      wait_idle();

      $display("Run covered %0d input words, %0d output bytes, %0d zlib streams",
               words_sent, bytes_checked, streams_done);
      $display("including empty streams, a capped first block, Adler wrap and hold-off");
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end

endmodule
